>>> hw/rtl/vthm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vthm_pkg
// Shared types and constants of the valve tracking health monitor.
// ----------------------------------------------------------------------------
package vthm_pkg;

  localparam int unsigned POS_W      = 10;
  localparam int unsigned LIMIT_W    = 16;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 8'd2;

  localparam logic [POS_W-1:0]   WARNING_RST  = 10'd50;
  localparam logic [POS_W-1:0]   CRITICAL_RST = 10'd150;
  localparam logic [LIMIT_W-1:0] LIMIT_RST    = 16'd3;
  localparam logic [LIMIT_W-1:0] RUN_MAX      = 16'hFFFF;

  // error classes
  localparam logic [1:0] CLS_OK   = 2'd0;
  localparam logic [1:0] CLS_WARN = 2'd1;
  localparam logic [1:0] CLS_CRIT = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0]   warning;
    logic [POS_W-1:0]   critical;
    logic [LIMIT_W-1:0] limit;
  } vthm_cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] err;
    logic [1:0]       cls;
  } vthm_item_t;

  typedef struct packed {
    logic [POS_W-1:0]   err;
    logic [1:0]         cls;
    logic [POS_W-1:0]   avg;
    logic [POS_W-1:0]   peak;
    logic [LIMIT_W-1:0] run;
    logic [TOTAL_W-1:0] total;
    logic               alarm;
    logic               healthy;
    logic               recovered;
  } vthm_result_t;

endpackage

>>> hw/rtl/vthm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vthm_front
// Input stage: forms the absolute tracking error, classifies it against the
// thresholds and holds it in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module vthm_front import vthm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [POS_W-1:0] commanded_position_i,
  input  logic [POS_W-1:0] actual_position_i,
  input  vthm_cfg_t        cfg_i,
  input  logic             deq_i,
  output logic             valid_o,
  output vthm_item_t       item_o
);

  vthm_item_t       slot_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [POS_W-1:0] err;
  vthm_item_t       item_in;
  logic             enq;

  always_comb begin
    if (commanded_position_i >= actual_position_i) begin
      err = commanded_position_i - actual_position_i;
    end else begin
      err = actual_position_i - commanded_position_i;
    end
    item_in.err = err;
    if (err > cfg_i.critical) begin
      item_in.cls = CLS_CRIT;
    end else if (err > cfg_i.warning) begin
      item_in.cls = CLS_WARN;
    end else begin
      item_in.cls = CLS_OK;
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rd_q];
  assign enq     = push_i && !full_o;

  always_comb begin
    wr_d  = enq ? !wr_q : wr_q;
    rd_d  = deq_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, enq} - {1'b0, deq_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      slot_q[wr_q] <= item_in;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("front queue count overflow");

  a_deq_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_i |-> valid_o) else $error("front queue read while empty");

endmodule

>>> hw/rtl/vthm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vthm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vthm_div #(
  parameter int unsigned DVD_W = 14,
  parameter int unsigned DVS_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned ITER_W = $clog2(DVD_W + 1);

  logic              busy_q, busy_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic [DVD_W-1:0]  dq_q, dq_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    rem_sh, diff;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q, dq_q[DVD_W-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    ge     = (rem_sh >= {1'b0, dvs_q});
    busy_d = busy_q;
    iter_d = iter_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = ITER_W'(DVD_W);
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d   = {dq_q[DVD_W-2:0], ge};
      rem_d  = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      iter_d = iter_q - ITER_W'(1);
      busy_d = (iter_q != ITER_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
      dq_q   <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      busy_q <= busy_d;
      iter_q <= iter_d;
      dq_q   <= dq_d;
      rem_q  <= rem_d;
      dvs_q  <= dvs_d;
    end
  end

  assign done_o     = !busy_q;
  assign quotient_o = dq_q;

endmodule

>>> hw/rtl/vthm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vthm_back
// Back end: updates the error history, run and total counters, scans the
// history for its peak, divides for the average and registers the result.
// ----------------------------------------------------------------------------
module vthm_back import vthm_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  vthm_cfg_t    cfg_i,
  input  logic         in_valid_i,
  input  vthm_item_t   in_item_i,
  output logic         in_deq_o,
  output logic         out_valid_o,
  output vthm_result_t out_o,
  input  logic         out_pop_i
);

  localparam int unsigned IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SUM_W  = POS_W + $clog2(HISTORY_DEPTH);
  localparam int unsigned PROD_W = POS_W + CNT_W;

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_SCAN, S_DONE} state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic [CNT_W-1:0]   filled_q, filled_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [LIMIT_W-1:0] run_q, run_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               was_q, was_d;
  vthm_item_t         item_q, item_d;
  logic               alarm_q, alarm_d;
  logic [CNT_W-1:0]   scan_q, scan_d;
  logic               rd_vld_q, rd_vld_d;
  logic [POS_W-1:0]   peak_q, peak_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic               out_valid_q, out_valid_d;
  vthm_result_t       out_q, out_d;

  logic [POS_W-1:0]   ring_q [HISTORY_DEPTH];
  logic [POS_W-1:0]   rd_data_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic               ring_full;
  logic               healthy;
  logic               div_start, div_done;
  logic [SUM_W-1:0]   quotient;

  assign ring_full = (filled_q == CNT_W'(HISTORY_DEPTH));
  assign healthy   = (run_q < cfg_i.limit) && (PROD_W'(sum_q) <= prod_q);

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    filled_d    = filled_q;
    sum_d       = sum_q;
    run_d       = run_q;
    total_d     = total_q;
    was_d       = was_q;
    item_d      = item_q;
    alarm_d     = alarm_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    peak_d      = peak_q;
    prod_d      = PROD_W'(cfg_i.warning) * PROD_W'(filled_q);
    out_valid_d = out_valid_q && !out_pop_i;
    out_d       = out_q;
    in_deq_o    = 1'b0;
    rd_addr     = slot_q;
    wr_en       = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        // fetch the entry about to be overwritten
        if (in_valid_i) begin
          in_deq_o = 1'b1;
          item_d   = in_item_i;
          state_d  = S_UPD;
        end
      end
      S_UPD: begin
        wr_en = 1'b1;
        if (ring_full) begin
          sum_d = sum_q - SUM_W'(rd_data_q) + SUM_W'(item_q.err);
        end else begin
          sum_d    = sum_q + SUM_W'(item_q.err);
          filled_d = filled_q + CNT_W'(1);
        end
        slot_d = (slot_q == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + IDX_W'(1);
        alarm_d = 1'b0;
        if (item_q.cls == CLS_CRIT) begin
          total_d = total_q + TOTAL_W'(1);
          if (run_q != RUN_MAX) begin
            run_d   = run_q + LIMIT_W'(1);
            alarm_d = (run_d == cfg_i.limit);
          end
        end else begin
          run_d = '0;
        end
        div_start = 1'b1;
        scan_d    = '0;
        peak_d    = '0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        rd_addr = scan_q[IDX_W-1:0];
        if (scan_q != filled_q) begin
          scan_d   = scan_q + CNT_W'(1);
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q && rd_data_q > peak_q) begin
          peak_d = rd_data_q;
        end
        if (scan_q == filled_q && !rd_vld_q && div_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (!out_valid_q || out_pop_i) begin
          out_d.err       = item_q.err;
          out_d.cls       = item_q.cls;
          out_d.avg       = quotient[POS_W-1:0];
          out_d.peak      = peak_q;
          out_d.run       = run_q;
          out_d.total     = total_q;
          out_d.alarm     = alarm_q;
          out_d.healthy   = healthy;
          out_d.recovered = was_q && healthy;
          out_valid_d     = 1'b1;
          was_d           = !healthy;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      filled_q    <= '0;
      sum_q       <= '0;
      run_q       <= '0;
      total_q     <= '0;
      was_q       <= 1'b0;
      item_q      <= '0;
      alarm_q     <= 1'b0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      peak_q      <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      filled_q    <= filled_d;
      sum_q       <= sum_d;
      run_q       <= run_d;
      total_q     <= total_d;
      was_q       <= was_d;
      item_q      <= item_d;
      alarm_q     <= alarm_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      peak_q      <= peak_d;
      prod_q      <= prod_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // history ring: unwritten entries may be read, but their data is used only once they have been written
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_q[slot_q] <= item_q.err;
    end
    rd_data_q <= ring_q[rd_addr];
  end

  vthm_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(sum_d),
    .divisor_i (filled_d),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(HISTORY_DEPTH)) else $error("history fill count overflow");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside completion");

  a_avg_le_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.avg <= out_q.peak)) else $error("average above peak");

endmodule

>>> hw/rtl/valve_tracking_health_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_tracking_health_monitor_unit
// Tracks commanded against measured valve position and reports error
// statistics, stuck counts and health per sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive the two positions and raise push; a sample is taken
//   on a clock edge with push high and full low. Two samples can wait ahead
//   of the processing stage.
//   Result queue: while empty is low the oldest result sits on the output
//   ports; pop high on an edge consumes it. One result register buffers it.
//   Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 warning, 1 critical,
//   2 stuck limit) and cfg_data_i; ready is always high, other indexes drop.
//   Processing: the serial divider for the average and the one-port
//   history scan for the peak set how long a sample takes; the back end
//   takes a new sample only once it has passed on the result of the last.
//   Stall: with pop held low the back end waits with a finished result and
//   the input queue fills, then full rises.
//   Reset: thresholds return to 50 and 150, limit to 3; history, counters
//   and recovery latch clear.
// ----------------------------------------------------------------------------
module valve_tracking_health_monitor_unit import vthm_pkg::*; #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [POS_W-1:0]      commanded_position_i,
  input  logic [POS_W-1:0]      actual_position_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [POS_W-1:0]      position_error_o,
  output logic [1:0]            error_class_o,
  output logic [POS_W-1:0]      average_error_o,
  output logic [POS_W-1:0]      peak_error_o,
  output logic [LIMIT_W-1:0]    consecutive_stuck_o,
  output logic [TOTAL_W-1:0]    total_stuck_o,
  output logic                  stuck_alarm_o,
  output logic                  healthy_o,
  output logic                  recovered_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  vthm_cfg_t    cfg_q;
  vthm_item_t   item;
  logic         item_valid, item_deq;
  logic         out_valid;
  vthm_result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.warning  <= WARNING_RST;
      cfg_q.critical <= CRITICAL_RST;
      cfg_q.limit    <= LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WARNING:  cfg_q.warning  <= cfg_data_i[POS_W-1:0];
        CFG_CRITICAL: cfg_q.critical <= cfg_data_i[POS_W-1:0];
        CFG_LIMIT:    cfg_q.limit    <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  vthm_front u_front (
    .clk_i,
    .rst_ni,
    .push_i              (push),
    .full_o              (full),
    .commanded_position_i,
    .actual_position_i,
    .cfg_i               (cfg_q),
    .deq_i               (item_deq),
    .valid_o             (item_valid),
    .item_o              (item)
  );

  vthm_back #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .in_valid_i (item_valid),
    .in_item_i  (item),
    .in_deq_o   (item_deq),
    .out_valid_o(out_valid),
    .out_o      (result),
    .out_pop_i  (pop && out_valid)
  );

  assign empty               = !out_valid;
  assign position_error_o    = result.err;
  assign error_class_o       = result.cls;
  assign average_error_o     = result.avg;
  assign peak_error_o        = result.peak;
  assign consecutive_stuck_o = result.run;
  assign total_stuck_o       = result.total;
  assign stuck_alarm_o       = result.alarm;
  assign healthy_o           = result.healthy;
  assign recovered_o         = result.recovered;

endmodule
